/* hdl/etwer_pkg.sv */
// Package for the timed event table: widths, command and status codes, shared types.
// Used by the top level, controller, datapath and checker of the event table block; depends on nothing.
package etwer_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned IdW        = 64;
  localparam int unsigned TimeW      = 40;
  localparam int unsigned DurW       = 24;
  localparam int unsigned LeadW      = 17;
  localparam int unsigned EntryW     = IdW + TimeW + DurW + 1;
  localparam logic [LeadW-1:0] LeadReset = LeadW'(15 * 60);

  typedef enum logic [1:0] {
    CmdAdd    = 2'd0,
    CmdRemove = 2'd1,
    CmdTick   = 2'd2,
    CmdRead   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StStored   = 3'd0,
    StDropped  = 3'd1,
    StRemoved  = 3'd2,
    StNotFound = 3'd3,
    StReminder = 3'd4,
    StTickDone = 3'd5,
    StSlotRead = 3'd6
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] start;
    logic [DurW-1:0]  dur;
    logic             all_day;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             latch;     // capture the input item
    logic             clr_scan;  // reset scan bookkeeping
    logic             rd_en;     // read slot at rd_addr
    logic [SlotW-1:0] rd_addr;
    logic             eval;      // evaluate the entry read last cycle
    logic             eval_tick; // evaluation is for tick
    logic             finish;    // produce the final result
    logic             emit_rem;  // produce a reminder result
  } ctrl_t;

  typedef struct packed {
    logic cmd_tick;
    logic cmd_read;
    logic rem_fire;   // entry under evaluation fires a reminder
  } stat_t;

endpackage

/* hdl/event_table_with_expiry_and_reminders.sv */
// Top level of the timed event table with expiry and reminders.
// Depends on etwer_pkg, etwer_ctrl, etwer_datapath and etwer_ram.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    command_i .. slot_index_i
//   output   out_valid / out_ready  status_o .. last_o
//   config   cfg_valid / cfg_ready  cfg_data_i (reminder lead)
//
// Add, remove and tick walk all sixteen slots through the single read port of the
// entry RAM, one slot per cycle, then finish; each reminder that fires holds the walk
// in a wait state until the output takes it. Read fetches only the slot at slot_index_i.
// Reset clears the used flags and sets the reminder lead to 900 seconds.
// A stalled output holds the walk at the next reminder or at the final result.
module event_table_with_expiry_and_reminders (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command_i,
  input  logic signed [63:0] event_id_i,
  input  logic [39:0]        start_time_i,
  input  logic [23:0]        duration_i,
  input  logic               all_day_i,
  input  logic [39:0]        now_time_i,
  input  logic [3:0]         slot_index_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status_o,
  output logic [3:0]         slot_o,
  output logic               entry_valid_o,
  output logic signed [63:0] out_event_id_o,
  output logic [39:0]        out_start_o,
  output logic [23:0]        out_duration_o,
  output logic               out_all_day_o,
  output logic               last_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [16:0]        cfg_data_i
);
  import etwer_pkg::*;

  logic [LeadW-1:0] lead_q;
  ctrl_t            ctrl;
  stat_t            stat;
  logic             out_load;
  logic [SlotW-1:0] found_slot, rslot;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= LeadReset;
    end else if (cfg_valid) begin
      lead_q <= cfg_data_i;
    end
  end

  etwer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_load_o  (out_load),
    .ctrl_o      (ctrl),
    .stat_i      (stat),
    .found_slot_i(found_slot),
    .rslot_i     (rslot)
  );

  etwer_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .found_slot_o  (found_slot),
    .rslot_o       (rslot),
    .command_i     (command_i),
    .event_id_i    (event_id_i),
    .start_time_i  (start_time_i),
    .duration_i    (duration_i),
    .all_day_i     (all_day_i),
    .now_time_i    (now_time_i),
    .slot_index_i  (slot_index_i),
    .lead_i        (lead_q),
    .out_load_i    (out_load),
    .status_o      (status_o),
    .slot_o        (slot_o),
    .entry_valid_o (entry_valid_o),
    .out_event_id_o(out_event_id_o),
    .out_start_o   (out_start_o),
    .out_duration_o(out_duration_o),
    .out_all_day_o (out_all_day_o),
    .last_o        (last_o)
  );
endmodule

/* hdl/etwer_ram.sv */
// Generic RAM with one write port and one registered read port.
// No dependencies.
module etwer_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/etwer_datapath.sv */
// Datapath of the event table: entry RAM, used/reminded flags, scan logic, result register.
// Depends on etwer_pkg and etwer_ram.
module etwer_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  etwer_pkg::ctrl_t           ctrl_i,
  output etwer_pkg::stat_t           stat_o,
  output logic [3:0]                 found_slot_o,
  output logic [3:0]                 rslot_o,
  input  logic [1:0]                 command_i,
  input  logic signed [63:0]         event_id_i,
  input  logic [39:0]                start_time_i,
  input  logic [23:0]                duration_i,
  input  logic                       all_day_i,
  input  logic [39:0]                now_time_i,
  input  logic [3:0]                 slot_index_i,
  input  logic [16:0]                lead_i,
  input  logic                       out_load_i,
  output logic [2:0]                 status_o,
  output logic [3:0]                 slot_o,
  output logic                       entry_valid_o,
  output logic signed [63:0]         out_event_id_o,
  output logic [39:0]                out_start_o,
  output logic [23:0]                out_duration_o,
  output logic                       out_all_day_o,
  output logic                       last_o
);
  import etwer_pkg::*;

  logic [1:0]       cmd_q;
  entry_t           req_q;
  logic [TimeW-1:0] now_q;
  logic [SlotW-1:0] rslot_q;

  logic [TableDepth-1:0] used_q, used_d;
  logic [TableDepth-1:0] rem_q, rem_d;

  logic [SlotW-1:0] ev_slot_q;
  logic             found_q, found_d;
  logic [SlotW-1:0] found_slot_q, found_slot_d;
  logic             free_q, free_d;
  logic [SlotW-1:0] free_slot_q, free_slot_d;
  logic [SlotW-1:0] late_slot_q, late_slot_d;
  logic [TimeW-1:0] late_start_q, late_start_d;
  logic             have_late_q, have_late_d;

  logic             we;
  logic [SlotW-1:0] waddr;
  entry_t           rd_ent;
  logic [EntryW-1:0] rd_raw;

  etwer_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(req_q),
    .raddr_i(ctrl_i.rd_addr),
    .rdata_o(rd_raw)
  );
  assign rd_ent = entry_t'(rd_raw);

  assign found_slot_o = found_slot_q;
  assign rslot_o      = rslot_q;

  logic             ev_used;
  logic [TimeW:0]   end_t;
  logic             expired;
  logic [TimeW:0]   due_t;
  logic             rem_fire;

  assign ev_used  = used_q[ev_slot_q];
  assign end_t    = {1'b0, rd_ent.start} + {17'd0, rd_ent.dur};
  assign expired  = {1'b0, now_q} > end_t;
  assign due_t    = {1'b0, now_q} + {24'd0, lead_i};
  assign rem_fire = ctrl_i.eval && ctrl_i.eval_tick && ev_used && !expired &&
                    !rd_ent.all_day && !rem_q[ev_slot_q] &&
                    (due_t >= {1'b0, rd_ent.start});

  assign stat_o.cmd_tick = (cmd_e'(cmd_q) == CmdTick);
  assign stat_o.cmd_read = (cmd_e'(cmd_q) == CmdRead);
  assign stat_o.rem_fire = rem_fire;

  logic add_ok;
  logic [SlotW-1:0] add_slot;
  always_comb begin
    add_ok   = 1'b1;
    add_slot = found_q ? found_slot_q : free_slot_q;
    if (!found_q && !free_q) begin
      add_slot = late_slot_q;
      add_ok   = have_late_q && (late_start_q > req_q.start);
    end
  end

  assign we    = ctrl_i.finish && (cmd_e'(cmd_q) == CmdAdd) && add_ok;
  assign waddr = add_slot;

  always_comb begin
    used_d       = used_q;
    rem_d        = rem_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    free_d       = free_q;
    free_slot_d  = free_slot_q;
    late_slot_d  = late_slot_q;
    late_start_d = late_start_q;
    have_late_d  = have_late_q;
    if (ctrl_i.clr_scan) begin
      found_d     = 1'b0;
      free_d      = 1'b0;
      have_late_d = 1'b0;
    end
    if (ctrl_i.eval && !ctrl_i.eval_tick) begin
      if (ev_used) begin
        if (!found_q && rd_ent.id == req_q.id) begin
          found_d      = 1'b1;
          found_slot_d = ev_slot_q;
        end
        if (!have_late_q || rd_ent.start > late_start_q) begin
          have_late_d  = 1'b1;
          late_slot_d  = ev_slot_q;
          late_start_d = rd_ent.start;
        end
      end else if (!free_q) begin
        free_d      = 1'b1;
        free_slot_d = ev_slot_q;
      end
    end
    if (ctrl_i.eval && ctrl_i.eval_tick && ev_used && expired) begin
      used_d[ev_slot_q] = 1'b0;
    end
    if (rem_fire) begin
      rem_d[ev_slot_q] = 1'b1;
    end
    if (we) begin
      used_d[add_slot] = 1'b1;
      rem_d[add_slot]  = (now_q >= req_q.start);
    end
    if (ctrl_i.finish && (cmd_e'(cmd_q) == CmdRemove) && found_q) begin
      used_d[found_slot_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    found_q      <= found_d;
    found_slot_q <= found_slot_d;
    free_q       <= free_d;
    free_slot_q  <= free_slot_d;
    late_slot_q  <= late_slot_d;
    late_start_q <= late_start_d;
    have_late_q  <= have_late_d;
    if (ctrl_i.rd_en) begin
      ev_slot_q <= ctrl_i.rd_addr;
    end
    if (ctrl_i.latch) begin
      cmd_q         <= command_i;
      req_q.id      <= event_id_i;
      req_q.start   <= start_time_i;
      req_q.dur     <= duration_i;
      req_q.all_day <= all_day_i;
      now_q         <= now_time_i;
      rslot_q       <= slot_index_i;
    end
  end

  // Result register, loaded when the controller hands over a result.
  logic [2:0]       st_n;
  logic [SlotW-1:0] sl_n;
  logic             ev_n, al_n, ls_n;
  entry_t           en_n;

  always_comb begin
    st_n = StTickDone;
    sl_n = '0;
    ev_n = 1'b0;
    en_n = '0;
    al_n = 1'b0;
    ls_n = 1'b1;
    if (ctrl_i.emit_rem) begin
      st_n = StReminder;
      sl_n = ev_slot_q;
      en_n = rd_ent;
      en_n.all_day = 1'b0;
      ls_n = 1'b0;
    end else begin
      case (cmd_e'(cmd_q))
        CmdAdd: begin
          en_n = req_q;
          if (add_ok) begin
            st_n = StStored;
            sl_n = add_slot;
          end else begin
            st_n = StDropped;
          end
        end
        CmdRemove: begin
          if (found_q) begin
            st_n = StRemoved;
            sl_n = found_slot_q;
            en_n = rd_ent;
          end else begin
            st_n = StNotFound;
            en_n.id = req_q.id;
          end
        end
        CmdRead: begin
          st_n = StSlotRead;
          sl_n = rslot_q;
          if (used_q[rslot_q]) begin
            ev_n = 1'b1;
            en_n = rd_ent;
          end
        end
        default: begin
          st_n = StTickDone;
        end
      endcase
    end
    al_n = en_n.all_day;
  end

  always_ff @(posedge clk_i) begin
    if (out_load_i) begin
      status_o       <= st_n;
      slot_o         <= sl_n;
      entry_valid_o  <= ev_n;
      out_event_id_o <= en_n.id;
      out_start_o    <= en_n.start;
      out_duration_o <= en_n.dur;
      out_all_day_o  <= al_n;
      last_o         <= ls_n;
    end
  end
endmodule

/* hdl/etwer_ctrl.sv */
// Controller of the event table: sequences slot scans, removal read-back and result handoff.
// Depends on etwer_pkg.
module etwer_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_load_o,
  output etwer_pkg::ctrl_t ctrl_o,
  input  etwer_pkg::stat_t stat_i,
  input  logic [3:0]       found_slot_i,
  input  logic [3:0]       rslot_i
);
  import etwer_pkg::*;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SScan  = 6'b000010,
    SFetch = 6'b000100,
    SFin   = 6'b001000,
    SWaitR = 6'b010000,
    SWaitF = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [SlotW:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_valid = out_valid_q;
  assign out_free  = !out_valid_q || out_ready;
  assign in_ready  = (state_q == SIdle);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready;
    out_load_o  = 1'b0;
    ctrl_o      = '0;
    ctrl_o.eval_tick = stat_i.cmd_tick;
    case (state_q)
      SIdle: begin
        if (in_valid) begin
          ctrl_o.latch    = 1'b1;
          ctrl_o.clr_scan = 1'b1;
          ctrl_o.rd_en    = 1'b1;
          ctrl_o.rd_addr  = '0;
          cnt_d           = '0;
          state_d         = SScan;
        end
      end
      SScan: begin
        // Entry at cnt_q is on the RAM output.
        if (stat_i.cmd_read) begin
          ctrl_o.rd_en   = 1'b1;
          ctrl_o.rd_addr = rslot_i;
          state_d        = SFin;
        end else begin
          ctrl_o.eval = 1'b1;
          if (stat_i.rem_fire) begin
            ctrl_o.rd_addr = cnt_q[SlotW-1:0];
            state_d        = SWaitR;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == (SlotW+1)'(TableDepth - 1)) begin
              ctrl_o.rd_en   = 1'b1;
              ctrl_o.rd_addr = found_slot_i;
              state_d        = SFetch;
            end else begin
              ctrl_o.rd_en   = 1'b1;
              ctrl_o.rd_addr = cnt_d[SlotW-1:0];
            end
          end
        end
      end
      SWaitR: begin
        ctrl_o.eval_tick = 1'b1;
        ctrl_o.rd_addr   = cnt_q[SlotW-1:0];
        if (out_free) begin
          ctrl_o.emit_rem = 1'b1;
          out_load_o      = 1'b1;
          out_valid_d     = 1'b1;
          cnt_d           = cnt_q + 1'b1;
          ctrl_o.rd_en    = 1'b1;
          if (cnt_q == (SlotW+1)'(TableDepth - 1)) begin
            ctrl_o.rd_addr = found_slot_i;
            state_d        = SFetch;
          end else begin
            ctrl_o.rd_addr = cnt_d[SlotW-1:0];
            state_d        = SScan;
          end
        end
      end
      SFetch: begin
        // Found-slot entry is being read for the remove result.
        ctrl_o.rd_en   = 1'b1;
        ctrl_o.rd_addr = found_slot_i;
        state_d        = SWaitF;
      end
      SFin, SWaitF: begin
        ctrl_o.rd_addr = stat_i.cmd_read ? rslot_i : found_slot_i;
        if (out_free) begin
          ctrl_o.finish = 1'b1;
          out_load_o    = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end
endmodule

/* hdl/etwer_checker.sv */
// Port-level checker for the event table, bound to the top level.
// Depends on etwer_pkg.
module etwer_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status_o,
  input logic       entry_valid_o,
  input logic       last_o
);
  import etwer_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status_o))
    else $error("Result changed while stalled.");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o == StReminder |-> !last_o)
    else $error("Reminder marked as final result.");

  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o != StReminder |-> last_o)
    else $error("Final result lacks last flag.");

  a_valid_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && entry_valid_o |-> status_o == StSlotRead)
    else $error("Entry valid on a non-read result.");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("Item accepted while busy.");
endmodule

bind event_table_with_expiry_and_reminders etwer_checker u_chk (.*);

/* dv/tb_event_table_with_expiry_and_reminders.sv */
// Testbench for the timed event table: a directed table, then random add, remove, tick and read
// items under random idling, all checked against an in-bench table predictor.
// Depends on etwer_pkg and event_table_with_expiry_and_reminders.
module tb_event_table_with_expiry_and_reminders;
  timeunit 1ns;
  timeprecision 1ps;
  import etwer_pkg::*;

  typedef struct {
    cmd_e             cmd;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] start;
    logic [DurW-1:0]  dur;
    logic             all_day;
    logic [TimeW-1:0] now;
    logic [SlotW-1:0] slot;
    logic             chk;
    status_e          st;
  } stim_row_t;

  typedef struct {
    status_e          status;
    logic [SlotW-1:0] slot;
    logic             valid;
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] start;
    logic [DurW-1:0]  dur;
    logic             all_day;
    logic             last;
  } result_t;

  localparam logic [IdW-1:0] IdMax = 64'h7fff_ffff_ffff_ffff;
  localparam logic [IdW-1:0] IdMin = 64'h8000_0000_0000_0000;
  localparam logic [TimeW-1:0] TMax = '1;
  localparam logic [DurW-1:0] DMax = '1;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] command_i = '0;
  logic signed [63:0] event_id_i = '0;
  logic [39:0] start_time_i = '0, now_time_i = '0;
  logic [23:0] duration_i = '0;
  logic all_day_i = 1'b0;
  logic [3:0] slot_index_i = '0;
  logic out_valid, out_ready = 1'b0;
  logic [2:0] status_o;
  logic [3:0] slot_o;
  logic entry_valid_o, out_all_day_o, last_o;
  logic signed [63:0] out_event_id_o;
  logic [39:0] out_start_o;
  logic [23:0] out_duration_o;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [16:0] cfg_data_i = '0;

  event_table_with_expiry_and_reminders i_dut (.*);

  always #1 clk_i = ~clk_i;

  logic             tbl_used [TableDepth];
  logic [IdW-1:0]   tbl_id [TableDepth];
  logic [TimeW-1:0] tbl_start [TableDepth];
  logic [DurW-1:0]  tbl_dur [TableDepth];
  logic             tbl_allday [TableDepth];
  logic             tbl_reminded [TableDepth];
  logic [LeadW-1:0] lead_secs;
  result_t          pending_q [$];
  int               fails = 0;
  int               cycles = 0;
  bit               calm = 0;
  bit               hold_req = 0;

  stim_row_t dir_tab [0:16] = '{
    '{CmdRead,   0,     0,    0,    0, 0,    0,  1, StSlotRead},
    '{CmdRead,   0,     0,    0,    0, 0,    15, 1, StSlotRead},
    '{CmdRemove, 5,     0,    0,    0, 0,    0,  1, StNotFound},
    '{CmdTick,   0,     0,    0,    0, 0,    0,  1, StTickDone},
    '{CmdAdd,    IdMax, 1000, 100,  0, 0,    0,  1, StStored},
    '{CmdAdd,    IdMin, TMax, DMax, 1, TMax, 0,  1, StStored},
    '{CmdAdd,    3,     2000, 10,   0, 2000, 0,  1, StStored},
    '{CmdAdd,    IdMax, 1500, 50,   0, 0,    0,  1, StStored},
    '{CmdTick,   0,     0,    0,    0, 700,  0,  1, StReminder},
    '{CmdTick,   0,     0,    0,    0, 700,  0,  1, StTickDone},
    '{CmdRead,   0,     0,    0,    0, 0,    1,  0, StSlotRead},
    '{CmdTick,   0,     0,    0,    0, 1551, 0,  1, StTickDone},
    '{CmdRemove, IdMin, 0,    0,    0, 0,    0,  1, StRemoved},
    '{CmdRemove, IdMin, 0,    0,    0, 0,    0,  1, StNotFound},
    '{CmdAdd,    4,     100,  0,    1, 0,    0,  1, StStored},
    '{CmdTick,   0,     0,    0,    0, 100,  0,  1, StTickDone},
    '{CmdRead,   0,     0,    0,    0, 0,    0,  0, StSlotRead}
  };

  function automatic result_t mk(status_e st, int s, logic v, logic [IdW-1:0] id,
                                 logic [TimeW-1:0] t, logic [DurW-1:0] d, logic a, logic l);
    result_t r;
    r.status = st; r.slot = s[SlotW-1:0]; r.valid = v; r.id = id;
    r.start = t; r.dur = d; r.all_day = a; r.last = l;
    return r;
  endfunction

  function automatic int find_event(logic [IdW-1:0] id);
    for (int s = 0; s < TableDepth; s++) begin
      if (tbl_used[s] && tbl_id[s] == id) return s;
    end
    return -1;
  endfunction

  function automatic int pick_slot(logic [TimeW-1:0] t);
    int latest;
    latest = -1;
    for (int s = 0; s < TableDepth; s++) begin
      if (!tbl_used[s]) return s;
      if (latest < 0 || tbl_start[s] > tbl_start[latest]) latest = s;
    end
    if (tbl_start[latest] > t) return latest;
    return -1;
  endfunction

  task automatic predict_table(stim_row_t r);
    int s, n;
    n = 0;
    case (r.cmd)
      CmdAdd: begin
        s = find_event(r.id);
        if (s < 0) s = pick_slot(r.start);
        if (s < 0) begin
          pending_q.push_back(mk(StDropped, 0, 0, r.id, r.start, r.dur, r.all_day, 1));
        end else begin
          tbl_used[s] = 1; tbl_id[s] = r.id; tbl_start[s] = r.start;
          tbl_dur[s] = r.dur; tbl_allday[s] = r.all_day;
          tbl_reminded[s] = (r.now >= r.start);
          pending_q.push_back(mk(StStored, s, 0, r.id, r.start, r.dur, r.all_day, 1));
        end
      end
      CmdRemove: begin
        s = find_event(r.id);
        if (s < 0) begin
          pending_q.push_back(mk(StNotFound, 0, 0, r.id, 0, 0, 0, 1));
        end else begin
          tbl_used[s] = 0;
          pending_q.push_back(mk(StRemoved, s, 0, tbl_id[s], tbl_start[s], tbl_dur[s],
                                 tbl_allday[s], 1));
        end
      end
      CmdTick: begin
        for (int k = 0; k < TableDepth; k++) begin
          if (!tbl_used[k]) continue;
          if (64'(r.now) > 64'(tbl_start[k]) + 64'(tbl_dur[k])) begin
            tbl_used[k] = 0;
            continue;
          end
          if (n < 16 && !tbl_allday[k] && !tbl_reminded[k] &&
              64'(r.now) + 64'(lead_secs) >= 64'(tbl_start[k])) begin
            tbl_reminded[k] = 1;
            pending_q.push_back(mk(StReminder, k, 0, tbl_id[k], tbl_start[k], tbl_dur[k],
                                   0, 0));
            n++;
          end
        end
        pending_q.push_back(mk(StTickDone, 0, 0, 0, 0, 0, 0, 1));
      end
      default: begin
        if (tbl_used[r.slot]) begin
          pending_q.push_back(mk(StSlotRead, r.slot, 1, tbl_id[r.slot], tbl_start[r.slot],
                                 tbl_dur[r.slot], tbl_allday[r.slot], 1));
        end else begin
          pending_q.push_back(mk(StSlotRead, r.slot, 0, 0, 0, 0, 0, 1));
        end
      end
    endcase
  endtask

  task automatic send_item(stim_row_t r);
    int first;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    command_i <= r.cmd; event_id_i <= r.id; start_time_i <= r.start;
    duration_i <= r.dur; all_day_i <= r.all_day; now_time_i <= r.now;
    slot_index_i <= r.slot;
    do @(posedge clk_i); while (!in_ready);
    first = pending_q.size();
    predict_table(r);
    if (r.chk && pending_q[first].status != r.st) begin
      $display("%0t: first status of table row expected %0d actual %0d", $time, r.st,
               pending_q[first].status);
      fails++;
    end
  endtask

  task automatic write_lead(logic [LeadW-1:0] v);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready);
    lead_secs = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic stim_row_t rand_item(logic [TimeW-1:0] base);
    stim_row_t r;
    int c;
    c = $urandom_range(0, 99);
    r.cmd = c < 45 ? CmdAdd : c < 60 ? CmdRemove : c < 85 ? CmdTick : CmdRead;
    c = $urandom_range(0, 23);
    r.id = c < 20 ? IdW'(c) : c == 20 ? IdMax : c == 21 ? IdMin : {$urandom, $urandom};
    r.start = $urandom_range(0, 9) == 0 ? TimeW'({$urandom, $urandom})
                                        : base + $urandom_range(0, 6000);
    r.dur = $urandom_range(0, 9) == 0 ? DurW'($urandom) : DurW'($urandom_range(0, 3000));
    r.all_day = $urandom_range(0, 4) == 0;
    r.now = $urandom_range(0, 29) == 0 ? TimeW'({$urandom, $urandom})
                                       : base + $urandom_range(0, 7000);
    r.slot = SlotW'($urandom);
    r.chk = 0;
    r.st = StStored;
    return r;
  endfunction

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with no expectation, status %0d", $time, status_o);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (status_o != e.status || slot_o != e.slot || entry_valid_o != e.valid ||
            out_event_id_o != e.id || out_start_o != e.start ||
            out_duration_o != e.dur || out_all_day_o != e.all_day || last_o != e.last) begin
          $display("%0t: expected st %0d slot %0d v %0b id %h start %h dur %h ad %b last %b",
                   $time, e.status, e.slot, e.valid, e.id, e.start, e.dur, e.all_day, e.last);
          $display("%0t: actual   st %0d slot %0d v %0b id %h start %h dur %h ad %b last %b",
                   $time, status_o, slot_o, entry_valid_o, out_event_id_o, out_start_o,
                   out_duration_o, out_all_day_o, last_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [LeadW-1:0] leads [4];
    logic [TimeW-1:0] base;
    for (int s = 0; s < TableDepth; s++) tbl_used[s] = 0;
    lead_secs = LeadReset;
    leads = '{0, 86400, LeadW'($urandom_range(1, 86399)), LeadReset};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    for (int p = 0; p < 4; p++) begin
      write_lead(leads[p]);
      base = TimeW'($urandom_range(0, 1000000));
      for (int i = 0; i < 52; i++) begin
        if (p == 1 && i == 10) hold_req = 1;
        if (p == 3 && i == 26) calm = 1;
        send_item(rand_item(base));
        if ($urandom_range(0, 9) == 0) base = base + $urandom_range(0, 3000);
      end
    end
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
